// File: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and types of the complex arithmetic unit: default widths,
// operation and status codes, and the sideband that rides the divider.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // operation codes
  localparam logic [2:0] KIND_CONJ = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // per-word flags carried alongside the quotient pipeline
  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic div_zero;
  } side_t;

endpackage

// File: src/cau_if.sv
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels of the complex arithmetic unit: operand words in,
// result words out.
// ----------------------------------------------------------------------------
interface cau_req_if #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic signed [W-1:0] a_re;
  logic signed [W-1:0] a_im;
  logic signed [W-1:0] b_re;
  logic signed [W-1:0] b_im;

  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r_re;
  logic signed [W-1:0] r_im;
  logic [1:0]          status;

  modport source (output valid, r_re, r_im, status, input ready);
  modport sink   (input valid, r_re, r_im, status, output ready);
endinterface

// File: src/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Conjugate, add, subtract, multiply and divide of signed fixed-point complex
// numbers, with saturation and a divide-by-zero status.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operand word (kind, a_re, a_im, b_re, b_im); rsp returns
//   one result word (r_re, r_im, status) per request, in order.
//   Throughput: one word per cycle, every operation, while rsp is not stalled.
//   Pipeline, the same for every kind: input register, multiplier stage,
//   sum/sign stage, divider overflow stage, DATA_WIDTH+1 divider bit stages
//   and the saturation/output register. The divider's bit-per-stage chain
//   sets the pipeline depth; non-divide words pass through it divided by one.
//   Stall: the whole pipeline holds while rsp.valid is high and rsp.ready is
//   low; req.ready is low during that time. No word is dropped or repeated.
//   Reset (rst, synchronous): all valid bits clear, the pipe is empty and
//   req.ready is high on the next cycle.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  cau_req_if.sink  req,
  cau_rsp_if.source rsp
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2*W;
  localparam int SW = 2*W+2;
  localparam int NW = 2*W+1;
  localparam int DW = SW+F;

  logic en;

  // stage 1: input register
  logic                v1;
  logic [2:0]          k1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  // stage 2: products
  logic                 v2;
  logic [2:0]           k2;
  logic signed [W-1:0]  ar2, ai2, br2, bi2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;

  // stage 3: sign/magnitude, dividend and divisor
  logic signed [SW-1:0] s_re, s_im;
  logic [NW-1:0]        nrm;
  logic                 is_div;
  logic                 is_mul;
  logic [SW-1:0]        m_re, m_im;
  logic                 v3;
  logic [DW-1:0]        dvd_re, dvd_im;
  logic [NW-1:0]        dvs;
  cau_pkg::side_t       side3;

  // divider outputs
  logic           vd;
  logic [W:0]     q_re, q_im;
  logic           ovf_re, ovf_im;
  cau_pkg::side_t sided;

  // output stage
  logic                sat_re, sat_im;
  logic [W:0]          lim_re, lim_im;
  logic [W:0]          val_re, val_im;
  logic                vo;
  logic signed [W-1:0] ro_re, ro_im;
  logic [1:0]          st_o;

  assign en        = !vo || rsp.ready;
  assign req.ready = en;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      vo <= vd;
    end
  end

  // input register and multipliers
  always_ff @(posedge clk) begin
    if (en) begin
      k1     <= req.kind;
      ar1    <= req.a_re;
      ai1    <= req.a_im;
      br1    <= req.b_re;
      bi1    <= req.b_im;
      k2     <= k1;
      ar2    <= ar1;
      ai2    <= ai1;
      br2    <= br1;
      bi2    <= bi1;
      p_rr   <= ar1 * br1;
      p_ii   <= ai1 * bi1;
      p_ri   <= ar1 * bi1;
      p_ir   <= ai1 * br1;
      p_bb_r <= br1 * br1;
      p_bb_i <= bi1 * bi1;
    end
  end

  // exact sums per operation
  always_comb begin
    s_re   = '0;
    s_im   = '0;
    is_div = 1'b0;
    is_mul = 1'b0;
    case (k2)
      cau_pkg::KIND_CONJ: begin
        s_re = SW'(ar2);
        s_im = -SW'(ai2);
      end
      cau_pkg::KIND_ADD: begin
        s_re = SW'(ar2) + SW'(br2);
        s_im = SW'(ai2) + SW'(bi2);
      end
      cau_pkg::KIND_SUB: begin
        s_re = SW'(ar2) - SW'(br2);
        s_im = SW'(ai2) - SW'(bi2);
      end
      cau_pkg::KIND_MUL: begin
        s_re   = SW'(p_rr) - SW'(p_ii);
        s_im   = SW'(p_ri) + SW'(p_ir);
        is_mul = 1'b1;
      end
      cau_pkg::KIND_DIV: begin
        s_re   = SW'(p_rr) + SW'(p_ii);
        s_im   = SW'(p_ir) - SW'(p_ri);
        is_div = 1'b1;
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    nrm  = NW'($unsigned(p_bb_r)) + NW'($unsigned(p_bb_i));
    m_re = s_re[SW-1] ? $unsigned(-s_re) : $unsigned(s_re);
    m_im = s_im[SW-1] ? $unsigned(-s_im) : $unsigned(s_im);
    if (is_mul) begin
      m_re = m_re >> F;
      m_im = m_im >> F;
    end
  end

  // stage 3 register: non-divide words are divided by one in Q format
  always_ff @(posedge clk) begin
    if (en) begin
      dvd_re         <= DW'(m_re) << F;
      dvd_im         <= DW'(m_im) << F;
      side3.neg_re   <= s_re[SW-1];
      side3.neg_im   <= s_im[SW-1];
      side3.div_zero <= is_div && (nrm == '0);
      if (!is_div) begin
        dvs <= NW'(1) << F;
      end else if (nrm == '0) begin
        dvs <= NW'(1);
      end else begin
        dvs <= nrm;
      end
    end
  end

  cau_divider #(
    .W (W),
    .F (F)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .dvd_re    (dvd_re),
    .dvd_im    (dvd_im),
    .dvs       (dvs),
    .side_in   (side3),
    .out_valid (vd),
    .q_re      (q_re),
    .q_im      (q_im),
    .ovf_re    (ovf_re),
    .ovf_im    (ovf_im),
    .side_out  (sided)
  );

  // saturate to the signed range
  always_comb begin
    lim_re = sided.neg_re ? (W+1)'(1) << (W-1) : ((W+1)'(1) << (W-1)) - (W+1)'(1);
    lim_im = sided.neg_im ? (W+1)'(1) << (W-1) : ((W+1)'(1) << (W-1)) - (W+1)'(1);
    sat_re = ovf_re || (q_re > lim_re);
    sat_im = ovf_im || (q_im > lim_im);
    val_re = sat_re ? lim_re : q_re;
    val_im = sat_im ? lim_im : q_im;
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (sided.div_zero) begin
        ro_re <= '0;
        ro_im <= '0;
        st_o  <= cau_pkg::ST_DIV0;
      end else begin
        ro_re <= sided.neg_re ? -$signed(val_re[W-1:0]) : $signed(val_re[W-1:0]);
        ro_im <= sided.neg_im ? -$signed(val_im[W-1:0]) : $signed(val_im[W-1:0]);
        st_o  <= (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  assign rsp.valid  = vo;
  assign rsp.r_re   = ro_re;
  assign rsp.r_im   = ro_im;
  assign rsp.status = st_o;

endmodule

// File: src/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider for two dividends over one shared divisor.
// One overflow stage, then one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module cau_divider #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*W+1+F:0]     dvd_re,
  input  logic [2*W+1+F:0]     dvd_im,
  input  logic [2*W:0]         dvs,
  input  cau_pkg::side_t       side_in,
  output logic                 out_valid,
  output logic [W:0]           q_re,
  output logic [W:0]           q_im,
  output logic                 ovf_re,
  output logic                 ovf_im,
  output cau_pkg::side_t       side_out
);

  localparam int NW = 2*W+1;
  localparam int XW = 3*W+F+3;
  localparam int NS = W+1;

  logic                 v   [0:NS];
  logic [XW-1:0]        rr  [0:NS];
  logic [XW-1:0]        ri  [0:NS];
  logic [NW-1:0]        nd  [0:NS];
  logic [W:0]           qr  [0:NS];
  logic [W:0]           qi  [0:NS];
  logic                 ovr [0:NS];
  logic                 ovi [0:NS];
  cau_pkg::side_t       sd  [0:NS];

  // overflow check: quotient would need more than W+1 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0]  <= XW'(dvd_re);
      ri[0]  <= XW'(dvd_im);
      nd[0]  <= dvs;
      qr[0]  <= '0;
      qi[0]  <= '0;
      ovr[0] <= XW'(dvd_re) >= (XW'(dvs) << NS);
      ovi[0] <= XW'(dvd_im) >= (XW'(dvs) << NS);
      sd[0]  <= side_in;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_bit
    localparam int K = W - i;
    logic [XW-1:0] t;
    logic          ge_re;
    logic          ge_im;

    assign t     = XW'(nd[i]) << K;
    assign ge_re = rr[i] >= t;
    assign ge_im = ri[i] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[i+1]  <= ge_re ? rr[i] - t : rr[i];
        ri[i+1]  <= ge_im ? ri[i] - t : ri[i];
        qr[i+1]  <= qr[i] | ((W+1)'(ge_re) << K);
        qi[i+1]  <= qi[i] | ((W+1)'(ge_im) << K);
        nd[i+1]  <= nd[i];
        ovr[i+1] <= ovr[i];
        ovi[i+1] <= ovi[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = v[NS];
  assign q_re      = qr[NS];
  assign q_im      = qi[NS];
  assign ovf_re    = ovr[NS];
  assign ovf_im    = ovi[NS];
  assign side_out  = sd[NS];

endmodule

// File: src/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic signed [W-1:0] r_re,
  input logic signed [W-1:0] r_im,
  input logic [1:0]          status
);

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(r_re) && $stable(r_im)
      && $stable(status))
    else $error("stalled result word changed");

  // divide by zero returns zero parts
  a_div0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cau_pkg::ST_DIV0 |-> r_re == '0 && r_im == '0)
    else $error("divide by zero with nonzero result");

  // saturated status puts some part at a range limit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cau_pkg::ST_SAT |->
      r_re == MAXV || r_re == MINV || r_im == MAXV || r_im == MINV)
    else $error("saturation flagged without a limit value");

endmodule

bind complex_arithmetic_unit cau_checker #(
  .W (DATA_WIDTH)
) u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .r_re      (rsp.r_re),
  .r_im      (rsp.r_im),
  .status    (rsp.status)
);
